>>> rtl/core/sha256_message_hasher_top_assert.svh
// Assertion macros for the SHA-256 message hasher top level.
// Included by the top level only; depends on nothing else.
`ifndef SHA256_MESSAGE_HASHER_TOP_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sha_pkg.sv
// Package for the SHA-256 message hasher: constants, types and round functions.
// Used by the interfaces, the compression core and the top level.
`timescale 1ns / 1ps

package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_bytes_0_7;
        logic [63:0] digest_bytes_8_15;
        logic [63:0] digest_bytes_16_23;
        logic [63:0] digest_bytes_24_31;
    } out_item_t;

    // Control between the top level and the compression core.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t big_s0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_s1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_s0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_s1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> rtl/core/sha_if.sv
// Valid/ready channel interfaces for the SHA-256 message hasher.
// Depends on sha_pkg for the payload types.
`timescale 1ns / 1ps

interface sha_in_if;
    logic              valid;
    logic              ready;
    sha_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sha_out_if;
    logic               valid;
    logic               ready;
    sha_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sha_core.sv
// SHA-256 compression core: schedule memory with registered reads,
// one round per cycle, and chaining update. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  sha_pkg::word_t     chain_in [8],
    // Block words are loaded one per cycle before start.
    input  logic               load_en,
    input  logic [3:0]         load_addr,
    input  sha_pkg::word_t     load_data,
    output sha_pkg::word_t     chain_out [8]
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_PRIME = 4'b0010,
        C_ROUND = 4'b0100,
        C_ADD   = 4'b1000
    } cstate_t;

    cstate_t    state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    word_t      wv_reg [8];
    word_t      wv_next [8];

    // Schedule memory, read ports registered. Window of 16 words kept in memory;
    // the four taps per round are read one round ahead.
    word_t      sched_mem [16];
    word_t      rd_w_reg, rd_w2_reg, rd_w7_reg, rd_w15_reg, rd_w16_reg;
    logic [5:0] rd_t;

    word_t      w_cur, t1, t2, sched_calc;
    logic       wr_en;
    logic [3:0] wr_addr;
    word_t      wr_data;

    // The round to be read for is the one after the current one.
    assign rd_t = (state_reg == C_ROUND) ? rnd_reg + 6'd1 : 6'd0;

    // The schedule word for round t >= 16 is built from registered taps.
    always_comb
    begin
        word_t x2, x7, x15, x16;
        x2  = rd_w2_reg;
        x7  = rd_w7_reg;
        x15 = rd_w15_reg;
        x16 = rd_w16_reg;
        sched_calc = small_s1(x2) + x7 + small_s0(x15) + x16;
        w_cur = (rnd_reg < 6'd16) ? rd_w_reg : sched_calc;
        t1 = wv_reg[7] + big_s1(wv_reg[4])
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
           + ROUND_K[rnd_reg] + w_cur;
        t2 = big_s0(wv_reg[0])
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    // Memory write port: block load or generated schedule word.
    always_comb
    begin
        wr_en   = load_en || (state_reg == C_ROUND && rnd_reg >= 6'd16);
        wr_addr = load_en ? load_addr : rnd_reg[3:0];
        wr_data = load_en ? load_data : sched_calc;
    end

    // The word for round t - 2 is written at the end of round t - 2 and read at the end
    // of round t - 1, so the plain read already sees it.
    always_ff @(posedge clk)
    begin
        logic [3:0] a2, a7, a15;
        a2  = 4'(rd_t - 6'd2);
        a7  = 4'(rd_t - 6'd7);
        a15 = 4'(rd_t - 6'd15);
        if (wr_en)
            sched_mem[wr_addr] <= wr_data;
        // Reads see the old contents; a colliding write is forwarded to the 7, 15 and 16 taps.
        rd_w_reg   <= sched_mem[rd_t[3:0]];
        rd_w2_reg  <= sched_mem[a2];
        rd_w7_reg  <= (wr_en && wr_addr == a7) ? wr_data : sched_mem[a7];
        rd_w15_reg <= (wr_en && wr_addr == a15) ? wr_data : sched_mem[a15];
        rd_w16_reg <= (wr_en && wr_addr == rd_t[3:0]) ? wr_data : sched_mem[rd_t[3:0]];
    end

    // Round sequencer.
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        wv_next    = wv_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                    state_next = C_PRIME;
            end
            C_PRIME:
            begin
                wv_next    = chain_in;
                rnd_next   = 6'd0;
                state_next = C_ROUND;
            end
            C_ROUND:
            begin
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'(ROUNDS - 1))
                    state_next = C_ADD;
            end
            C_ADD:
                state_next = C_IDLE;
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg <= wv_next;
    end

    // Chaining sum presented while the core reports done.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            chain_out[i] = chain_in[i] + wv_reg[i];
    end

    assign busy = (state_reg != C_IDLE);
    assign done = (state_reg == C_ADD);

endmodule

>>> rtl/core/sha256_message_hasher_top.sv
// SHA-256 message hasher: byte intake, padding and digest output; uses sha_pkg, sha_if, sha_core.
// A full block closes the input while it is loaded into the core, started and compressed;
// an end transaction pads the buffer, then compresses one block, or two when the length
// does not fit; then the digest is valid. Input waits until the digest is taken.
// Reset: asynchronous, active low; chaining words return to the initial hash value.
`timescale 1ns / 1ps
`include "sha256_message_hasher_top_assert.svh"

module sha256_message_hasher_top
(
    input logic       clk,
    input logic       rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

    typedef enum logic [6:0] {
        S_IN    = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_START = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_HOLD  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  ld_reg, ld_next;
    logic        final_reg, final_next;   // Block being compressed is the last.
    logic        lenblk_reg, lenblk_next; // Padding block carries the length.
    logic        pend_end_reg;
    word_t       chain_reg [8];
    word_t       chain_out [8];
    out_item_t   out_reg;
    logic        out_valid_reg;

    // Block buffer: word memory with byte-lane writes and one registered word read per cycle.
    word_t       buf_mem [16];
    logic        buf_we;
    logic [5:0]  buf_wa;
    logic [7:0]  buf_wd;
    word_t       buf_rd_reg;
    logic        load_en_reg;
    logic [3:0]  load_addr_reg;

    logic        core_start;
    logic        core_busy;
    logic        core_done;
    logic        acc;
    logic [63:0] bits;

    assign acc  = in_ch.valid && in_ch.ready;
    assign bits = {count_reg, 3'b000};
    assign in_ch.ready = (state_reg == S_IN);

    // Byte 0 of a word sits in its most significant lane.
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_wa[5:2]][{~buf_wa[1:0], 3'b000} +: 8] <= buf_wd;
        buf_rd_reg <= buf_mem[ld_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_en_reg   <= 1'b0;
            load_addr_reg <= '0;
        end
        else
        begin
            load_en_reg   <= (state_reg == S_LOAD);
            load_addr_reg <= ld_reg;
        end
    end

    // Intake, padding and block sequencing.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        ld_next     = ld_reg;
        final_next  = final_reg;
        lenblk_next = lenblk_reg;
        buf_we      = 1'b0;
        buf_wa      = pos_reg;
        buf_wd      = in_ch.data.msg_byte;
        core_start  = 1'b0;
        case (state_reg)
            S_IN:
            begin
                if (acc)
                begin
                    if (in_ch.data.byte_present)
                    begin
                        buf_we     = 1'b1;
                        count_next = count_reg + 61'd1;
                        pos_next   = pos_reg + 6'd1;
                    end
                    final_next = 1'b0;
                    if (in_ch.data.byte_present && pos_reg == 6'(BLOCK_BYTES - 1))
                    begin
                        ld_next    = '0;
                        state_next = S_LOAD;
                    end
                    else if (in_ch.data.end_of_message)
                        state_next = S_PAD;
                    lenblk_next = 1'b0;
                end
            end
            S_PAD:
            begin
                // Write the pad byte first, then zeros, then the length.
                buf_we = 1'b1;
                if (!lenblk_reg && pos_reg == count_reg[5:0])
                    buf_wd = PAD_BYTE;
                else if (pos_reg >= 6'd56)
                    buf_wd = bits[{~pos_reg[2:0], 3'b111} -: 8];
                else
                    buf_wd = 8'd0;
                // First pad block that has no room for the length.
                if (!lenblk_reg && count_reg[5:0] >= 6'd56)
                begin
                    buf_wd = (pos_reg == count_reg[5:0]) ? PAD_BYTE : 8'd0;
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        final_next  = 1'b0;
                        lenblk_next = 1'b1;
                        ld_next     = '0;
                        state_next  = S_LOAD;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        final_next = 1'b1;
                        ld_next    = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                ld_next = ld_reg + 4'd1;
                if (ld_reg == 4'd15)
                    state_next = S_START;
            end
            S_START:
            begin
                core_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (core_done)
                begin
                    if (final_reg)
                        state_next = S_OUT;
                    else if (lenblk_reg)
                    begin
                        pos_next   = '0;
                        state_next = S_PAD;
                    end
                    else
                        state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                // After a full block: pad if its end mark is still to be handled, else return to intake.
                state_next = pend_end_reg ? S_PAD : S_IN;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    count_next = '0;
                    pos_next   = '0;
                    state_next = S_IN;
                end
            end
            default:
                state_next = S_IN;
        endcase
    end

    // End mark of the last accepted transaction; used after a full block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_end_reg <= 1'b0;
        else if (state_reg == S_IN && acc)
            pend_end_reg <= in_ch.data.end_of_message;
        else if (state_reg == S_HOLD)
            pend_end_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IN;
            count_reg  <= '0;
            pos_reg    <= '0;
            ld_reg     <= '0;
            final_reg  <= 1'b0;
            lenblk_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            ld_reg     <= ld_next;
            final_reg  <= final_next;
            lenblk_reg <= lenblk_next;
        end
    end

    // Chaining words: updated when the core finishes, reloaded after a digest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_reg <= INIT_HASH;
        else if (core_done)
            chain_reg <= chain_out;
        else if (state_reg == S_OUT && !out_valid_reg)
            chain_reg <= INIT_HASH;
    end

    sha_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .busy      (core_busy),
        .done      (core_done),
        .chain_in  (chain_reg),
        .load_en   (load_en_reg),
        .load_addr (load_addr_reg),
        .load_data (buf_rd_reg),
        .chain_out (chain_out)
    );

    // Output register: loaded when the final block finishes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_done && final_reg)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_done && final_reg)
        begin
            out_reg.digest_bytes_0_7   <= {chain_out[0], chain_out[1]};
            out_reg.digest_bytes_8_15  <= {chain_out[2], chain_out[3]};
            out_reg.digest_bytes_16_23 <= {chain_out[4], chain_out[5]};
            out_reg.digest_bytes_24_31 <= {chain_out[6], chain_out[7]};
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    `SHA_ASSERT_IMPL(a_no_intake_busy, core_busy, !in_ch.ready, "intake open while compressing")
    `SHA_ASSERT_NEXT(a_start_busy, core_start, core_busy, "core did not start")
    `SHA_ASSERT_IMPL(a_out_final, core_done && !final_reg, !out_valid_reg || state_reg != S_OUT, "digest pending on a non-final block")

endmodule
